FILE: design/assert_macros.svh
// Assertion helpers for the power calculation block.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// antecedent true -> consequent true in the same cycle
`define ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// antecedent true -> consequent true in the next cycle
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_SAME(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

FILE: design/pmpc_pkg.sv
package pmpc_pkg;

    localparam int CNT_W    = 32;
    localparam int TIME_W   = 32;
    localparam int FACTOR_W = 32;
    localparam int SHORT_W  = 16;
    localparam int PROD_W   = 64;
    localparam int POWER_W  = 48;

    // seconds per hour times watts per kilowatt
    localparam int unsigned SEC_PER_HOUR = 3600;
    localparam int unsigned W_PER_KW     = 1000;
    localparam logic [FACTOR_W-1:0] K_POWER = FACTOR_W'(SEC_PER_HOUR * W_PER_KW);
    localparam int K_W = 22;

    // dividend: 64-bit product times a 22-bit constant
    localparam int NUM_W     = PROD_W + K_W;
    localparam int DIV_STEPS = NUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [POWER_W-1:0] POWER_MAX = {POWER_W{1'b1}};
    localparam logic [SHORT_W-1:0] SHORT_MAX = {SHORT_W{1'b1}};

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VOLUME_FACTOR = 3'd0,
        REG_ENERGY_FACTOR = 3'd1,
        REG_COUNT_DELTA   = 3'd2,
        REG_ELASTICITY    = 3'd3,
        REG_INITIAL_COUNT = 3'd4,
        REG_START_TIME    = 3'd5
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_VOL,
        ST_MUL_ENE,
        ST_MUL_PWR,
        ST_MUL_KLO,
        ST_MUL_KHI,
        ST_ACC_NUM,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_VOL,
        MUL_ENE,
        MUL_PWR,
        MUL_KLO,
        MUL_KHI
    } mul_sel_t;

    typedef struct packed {
        logic     accept;
        mul_sel_t mul_sel;
        logic     vol_ld;
        logic     ene_ld;
        logic     phi_ld;
        logic     num_ld;
        logic     num_acc;
        logic     div_init;
        logic     div_step;
        logic     out_ld;
    } pmpc_cmd_t;

    typedef struct packed {
        logic need_power;
    } pmpc_status_t;

endpackage

FILE: design/pmpc_ctrl.sv
module pmpc_ctrl
    import pmpc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  pmpc_status_t status,
    output pmpc_cmd_t    cmd
);

    state_t               state_reg, state_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic                 out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        cmd.mul_sel  = MUL_NONE;
        s_tready     = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_MUL_VOL;
                end
            end
            ST_MUL_VOL: begin
                cmd.mul_sel = MUL_VOL;
                state_next  = ST_MUL_ENE;
            end
            ST_MUL_ENE: begin
                cmd.mul_sel = MUL_ENE;
                cmd.vol_ld  = 1'b1;
                state_next  = ST_MUL_PWR;
            end
            ST_MUL_PWR: begin
                cmd.mul_sel = MUL_PWR;
                cmd.ene_ld  = 1'b1;
                state_next  = status.need_power ? ST_MUL_KLO : ST_FINISH;
            end
            ST_MUL_KLO: begin
                cmd.mul_sel = MUL_KLO;
                cmd.phi_ld  = 1'b1;
                state_next  = ST_MUL_KHI;
            end
            ST_MUL_KHI: begin
                cmd.mul_sel = MUL_KHI;
                cmd.num_ld  = 1'b1;
                state_next  = ST_ACC_NUM;
            end
            ST_ACC_NUM: begin
                cmd.num_acc  = 1'b1;
                cmd.div_init = 1'b1;
                div_cnt_next = '0;
                state_next   = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // wait here only while the previous result is still unclaimed
                if (!out_valid_reg || m_tready) begin
                    cmd.out_ld = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_ld) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

FILE: design/pmpc_datapath.sv
module pmpc_datapath
    import pmpc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  pmpc_cmd_t             cmd,
    output pmpc_status_t          status,
    input  logic [CNT_W-1:0]      in_count,
    input  logic [TIME_W-1:0]     in_time,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic [CNT_W-1:0]      out_count,
    output logic [PROD_W-1:0]     out_volume,
    output logic [PROD_W-1:0]     out_energy,
    output logic                  out_updated,
    output logic [POWER_W-1:0]    out_power,
    output logic [SHORT_W-1:0]    out_range
);

    // configuration
    logic [FACTOR_W-1:0] vol_factor_reg, vol_factor_next;
    logic [FACTOR_W-1:0] ene_factor_reg, ene_factor_next;
    logic [SHORT_W-1:0]  count_delta_reg, count_delta_next;
    logic [SHORT_W-1:0]  elasticity_reg, elasticity_next;
    logic [CNT_W-1:0]    init_count_reg, init_count_next;
    logic [TIME_W-1:0]   start_time_reg, start_time_next;

    // running state
    logic [CNT_W-1:0]    prev_count_reg;
    logic [TIME_W-1:0]   prev_time_reg;
    logic [SHORT_W-1:0]  read_cycles_reg;
    logic                force_reg;

    // per-read working registers
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    diff_reg;
    logic [TIME_W-1:0]   span_reg;
    logic                upd_reg;
    logic                need_power_reg;
    logic [SHORT_W-1:0]  range_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [PROD_W-1:0]   vol_reg;
    logic [PROD_W-1:0]   ene_reg;
    logic [FACTOR_W-1:0] p_hi_reg;
    logic [NUM_W-1:0]    num_reg;
    logic [TIME_W-1:0]   rem_reg;
    logic [POWER_W-1:0]  quo_reg;
    logic                ovf_reg;

    logic [SHORT_W-1:0]  rc_inc;
    logic [CNT_W:0]      count_thresh;
    logic                upd;
    logic [FACTOR_W-1:0] mul_a, mul_b;
    logic [TIME_W:0]     rem_shift;
    logic                rem_ge;
    logic [TIME_W:0]     rem_sub;

    always_comb begin
        vol_factor_next  = vol_factor_reg;
        ene_factor_next  = ene_factor_reg;
        count_delta_next = count_delta_reg;
        elasticity_next  = elasticity_reg;
        init_count_next  = init_count_reg;
        start_time_next  = start_time_reg;
        case (cfg_reg_t'(cfg_index))
            REG_VOLUME_FACTOR: vol_factor_next  = cfg_data;
            REG_ENERGY_FACTOR: ene_factor_next  = cfg_data;
            REG_COUNT_DELTA:   count_delta_next = cfg_data[SHORT_W-1:0];
            REG_ELASTICITY:    elasticity_next  = cfg_data[SHORT_W-1:0];
            REG_INITIAL_COUNT: init_count_next  = cfg_data;
            REG_START_TIME:    start_time_next  = cfg_data;
            default: ;
        endcase
    end

    // recalculation decision
    assign rc_inc       = (read_cycles_reg != SHORT_MAX) ? read_cycles_reg + 1'b1
                                                         : read_cycles_reg;
    assign count_thresh = {1'b0, prev_count_reg} + {{(CNT_W+1-SHORT_W){1'b0}}, count_delta_reg};
    assign upd          = ({1'b0, in_count} >= count_thresh)
                          || (rc_inc >= elasticity_reg) || force_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vol_factor_reg  <= FACTOR_W'(65536);
            ene_factor_reg  <= FACTOR_W'(65536);
            count_delta_reg <= SHORT_W'(1);
            elasticity_reg  <= SHORT_W'(10);
            init_count_reg  <= '0;
            start_time_reg  <= '0;
            prev_count_reg  <= '0;
            prev_time_reg   <= '0;
            read_cycles_reg <= '0;
            force_reg       <= 1'b1;
        end else if (cfg_we && (cfg_index <= CFG_IDX_W'(REG_START_TIME))) begin
            vol_factor_reg  <= vol_factor_next;
            ene_factor_reg  <= ene_factor_next;
            count_delta_reg <= count_delta_next;
            elasticity_reg  <= elasticity_next;
            init_count_reg  <= init_count_next;
            start_time_reg  <= start_time_next;
            prev_count_reg  <= init_count_next;
            prev_time_reg   <= start_time_next;
            read_cycles_reg <= '0;
            force_reg       <= 1'b1;
        end else if (cmd.accept) begin
            force_reg <= 1'b0;
            if (upd) begin
                prev_count_reg  <= in_count;
                prev_time_reg   <= in_time;
                read_cycles_reg <= '0;
            end else begin
                read_cycles_reg <= rc_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            cnt_reg        <= in_count;
            diff_reg       <= in_count - prev_count_reg;
            span_reg       <= in_time - prev_time_reg;
            upd_reg        <= upd;
            need_power_reg <= upd && (in_time > prev_time_reg);
            range_reg      <= rc_inc;
        end
    end

    assign status.need_power = need_power_reg;

    // shared 32x32 multiplier
    always_comb begin
        case (cmd.mul_sel)
            MUL_VOL: begin
                mul_a = cnt_reg;
                mul_b = vol_factor_reg;
            end
            MUL_ENE: begin
                mul_a = cnt_reg;
                mul_b = ene_factor_reg;
            end
            MUL_PWR: begin
                mul_a = diff_reg;
                mul_b = ene_factor_reg;
            end
            MUL_KLO: begin
                mul_a = prod_reg[FACTOR_W-1:0];
                mul_b = K_POWER;
            end
            MUL_KHI: begin
                mul_a = p_hi_reg;
                mul_b = K_POWER;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        if (cmd.vol_ld) begin
            vol_reg <= prod_reg;
        end
        if (cmd.ene_ld) begin
            ene_reg <= prod_reg;
        end
        if (cmd.phi_ld) begin
            p_hi_reg <= prod_reg[PROD_W-1:FACTOR_W];
        end
    end

    // restoring divider, one quotient bit a cycle; bits past 48 only set the overflow flag
    assign rem_shift = {rem_reg, num_reg[NUM_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, span_reg};
    assign rem_sub   = rem_shift - {1'b0, span_reg};

    always_ff @(posedge aclk) begin
        if (cmd.num_ld) begin
            num_reg <= NUM_W'(prod_reg);
        end else if (cmd.num_acc) begin
            num_reg <= num_reg + {prod_reg[NUM_W-FACTOR_W-1:0], {FACTOR_W{1'b0}}};
        end else if (cmd.div_step) begin
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
        end

        if (cmd.div_init) begin
            rem_reg <= '0;
            quo_reg <= '0;
            ovf_reg <= 1'b0;
        end else if (cmd.div_step) begin
            rem_reg <= rem_ge ? rem_sub[TIME_W-1:0] : rem_shift[TIME_W-1:0];
            quo_reg <= {quo_reg[POWER_W-2:0], rem_ge};
            ovf_reg <= ovf_reg | quo_reg[POWER_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_ld) begin
            out_count   <= cnt_reg;
            out_volume  <= vol_reg;
            out_energy  <= ene_reg;
            out_updated <= upd_reg;
            out_range   <= range_reg;
            if (!need_power_reg) begin
                out_power <= '0;
            end else if (ovf_reg) begin
                out_power <= POWER_MAX;
            end else begin
                out_power <= quo_reg;
            end
        end
    end

endmodule

FILE: design/pulse_meter_power_calc.sv
// Pulse meter read and power calculation. Each input beat is one meter read (pulse count and
// timestamp in seconds); each output beat carries the count, volume and energy (count times
// the configured Q16.16 factors, exact 64-bit products) and, when a recalculation is due,
// the power in watts as Q16.16, floor(count growth * energy factor * 3600000 / seconds),
// saturated at 48 bits and zero when no time has passed or time went backwards. One 32x32
// multiplier is shared over five products and the quotient comes from a restoring divider
// at one bit a cycle over 86 bits. A read needing no power figure skips the divider; the next
// read is taken once the current one is in the output register. Configuration writes are
// taken at any time but must only be issued while the block is idle; every write to a mapped
// register reloads the count and time baselines.
`include "assert_macros.svh"

module pulse_meter_power_calc
    import pmpc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [63:0]           s_tdata,    // pulse_count[31:0], timestamp_s[63:32]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // count_out[31:0], volume_q16[95:32], energy_q16[159:96], power_w_q16[207:160],
    // range_cycles[223:208]
    output logic [223:0]          m_tdata,
    output logic [0:0]            m_tuser,    // power_updated[0]
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    pmpc_cmd_t          cmd;
    pmpc_status_t       status;
    logic [CNT_W-1:0]   out_count;
    logic [PROD_W-1:0]  out_volume;
    logic [PROD_W-1:0]  out_energy;
    logic               out_updated;
    logic [POWER_W-1:0] out_power;
    logic [SHORT_W-1:0] out_range;

    assign cfg_ready = 1'b1;

    pmpc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pmpc_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .in_count    (s_tdata[31:0]),
        .in_time     (s_tdata[63:32]),
        .cfg_we      (cfg_valid & cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_count   (out_count),
        .out_volume  (out_volume),
        .out_energy  (out_energy),
        .out_updated (out_updated),
        .out_power   (out_power),
        .out_range   (out_range)
    );

    assign m_tdata = {out_range, out_power, out_energy, out_volume, out_count};
    assign m_tuser = out_updated;

    // an accepted read keeps the input side closed for at least the next cycle
    `ASSERT_NEXT(a_busy_after_beat, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // the divider only runs for reads that need a power figure
    `ASSERT_SAME(a_div_needs_power, aclk, aresetn, cmd.div_step, status.need_power)
    // no power value without an update flag
    `ASSERT_SAME(a_power_zero, aclk, aresetn, m_tvalid && !m_tuser[0], m_tdata[207:160] == '0)

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import pmpc_pkg::*;

    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int SETTLE_CYCLES    = 8;
    localparam int END_DRAIN_CYCLES = 200;
    localparam int REPORT_LIMIT     = 10;
    localparam logic [31:0] WS_PER_KWH = 32'd3600000;
    localparam logic [31:0] WORD_MAX   = 32'hFFFF_FFFF;
    // indexes beyond the register map; writes there must leave everything alone
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [31:0] count_out;
        logic [63:0] volume_q16;
        logic [63:0] energy_q16;
        logic        power_updated;
        logic [47:0] power_w_q16;
        logic [15:0] range_cycles;
    } meter_read_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [63:0]           s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [223:0]          m_tdata;
    logic [0:0]            m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // register shadow and interval state of the meter
    logic [31:0] vol_factor;
    logic [31:0] ene_factor;
    logic [15:0] growth_step;
    logic [15:0] read_limit;
    logic [31:0] base_count;
    logic [31:0] base_time;
    logic [31:0] last_count;
    logic [31:0] last_time;
    logic [15:0] reads_open;
    logic        recalc_forced;

    meter_read_t expected_reads[$];
    meter_read_t seen_read;

    int fail_count;
    int reads_sent;
    int reads_checked;
    int power_updates;
    int cfg_writes;
    int idle_cycles;
    int gap_pct;
    int stall_pct;
    int stall_left;
    logic beat_seen;

    pulse_meter_power_calc dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void reload_baseline();
        last_count    = base_count;
        last_time     = base_time;
        reads_open    = '0;
        recalc_forced = 1'b1;
    endfunction

    function automatic void reset_meter_model();
        vol_factor  = 32'd65536;
        ene_factor  = 32'd65536;
        growth_step = 16'd1;
        read_limit  = 16'd10;
        base_count  = '0;
        base_time   = '0;
        reload_baseline();
    endfunction

    function automatic void load_meter_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        logic known;
        known = 1'b1;
        case (idx)
            REG_VOLUME_FACTOR: vol_factor  = val;
            REG_ENERGY_FACTOR: ene_factor  = val;
            REG_COUNT_DELTA:   growth_step = val[15:0];
            REG_ELASTICITY:    read_limit  = val[15:0];
            REG_INITIAL_COUNT: base_count  = val;
            REG_START_TIME:    base_time   = val;
            default:           known = 1'b0;
        endcase
        if (known) begin
            reload_baseline();
        end
    endfunction

    function automatic meter_read_t meter_step(logic [31:0] cnt, logic [31:0] ts);
        meter_read_t  r;
        logic [32:0]  growth_mark;
        logic [31:0]  diff;
        logic [31:0]  span;
        logic [127:0] scaled;
        logic [127:0] quot;
        logic         recalc;
        if (reads_open != SHORT_MAX) begin
            reads_open = reads_open + 16'd1;
        end
        // the threshold must not wrap past the top of the count range
        growth_mark = {1'b0, last_count} + 33'(growth_step);
        recalc = ({1'b0, cnt} >= growth_mark) || (reads_open >= read_limit) || recalc_forced;
        r.count_out     = cnt;
        r.volume_q16    = 64'(cnt) * 64'(vol_factor);
        r.energy_q16    = 64'(cnt) * 64'(ene_factor);
        r.power_updated = recalc;
        r.power_w_q16   = '0;
        r.range_cycles  = reads_open;
        if (recalc) begin
            if (ts > last_time) begin
                diff   = cnt - last_count;
                span   = ts - last_time;
                scaled = 128'(diff) * 128'(ene_factor) * 128'(WS_PER_KWH);
                quot   = scaled / 128'(span);
                r.power_w_q16 = (quot > 128'(POWER_MAX)) ? POWER_MAX : quot[POWER_W-1:0];
            end
            last_count = cnt;
            last_time  = ts;
            reads_open = '0;
        end
        recalc_forced = 1'b0;
        return r;
    endfunction

    function automatic string fmt_read(meter_read_t r);
        return $sformatf("count=%h vol=%h ene=%h upd=%b pwr=%h cyc=%0d", r.count_out,
                         r.volume_q16, r.energy_q16, r.power_updated, r.power_w_q16,
                         r.range_cycles);
    endfunction

    function automatic void report_failure(string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
    endfunction

    function automatic void check_read(meter_read_t got);
        meter_read_t want;
        string       diffs;
        if (expected_reads.size() == 0) begin
            report_failure({"result beat with nothing expected: ", fmt_read(got)});
            return;
        end
        want  = expected_reads.pop_front();
        diffs = "";
        if (got.count_out !== want.count_out) diffs = {diffs, " count_out"};
        if (got.volume_q16 !== want.volume_q16) diffs = {diffs, " volume_q16"};
        if (got.energy_q16 !== want.energy_q16) diffs = {diffs, " energy_q16"};
        if (got.power_updated !== want.power_updated) diffs = {diffs, " power_updated"};
        if (got.power_w_q16 !== want.power_w_q16) diffs = {diffs, " power_w_q16"};
        if (got.range_cycles !== want.range_cycles) diffs = {diffs, " range_cycles"};
        if (diffs != "") begin
            report_failure($sformatf("read %0d wrong in%s\n    expected %s\n    actual   %s",
                                     reads_checked, diffs, fmt_read(want), fmt_read(got)));
        end
        if (want.power_updated) power_updates++;
        reads_checked++;
    endfunction

    // all beats are observed here, at the rising edge, so ordering is fixed
    always @(posedge aclk) begin
        if (aresetn) begin
            beat_seen = 1'b0;
            if (cfg_valid && cfg_ready) begin
                load_meter_register(cfg_index, cfg_data);
                cfg_writes++;
                beat_seen = 1'b1;
            end
            if (m_tvalid && m_tready) begin
                seen_read.count_out     = m_tdata[31:0];
                seen_read.volume_q16    = m_tdata[95:32];
                seen_read.energy_q16    = m_tdata[159:96];
                seen_read.power_w_q16   = m_tdata[207:160];
                seen_read.range_cycles  = m_tdata[223:208];
                seen_read.power_updated = m_tuser[0];
                check_read(seen_read);
                beat_seen = 1'b1;
            end
            if (s_tvalid && s_tready) begin
                expected_reads.push_back(meter_step(s_tdata[31:0], s_tdata[63:32]));
                reads_sent++;
                beat_seen = 1'b1;
            end
            idle_cycles = beat_seen ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("ERROR @%0t: no beat for %0d cycles, %0d results outstanding",
                         $time, idle_cycles, expected_reads.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // result side back-pressure in bursts
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready = 1'b0;
            stall_left--;
        end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
            m_tready   = 1'b0;
            stall_left = $urandom_range(0, 6);
        end else begin
            m_tready = 1'b1;
        end
    end

    // valid is left high after the beat; the next call or release_reads decides
    task automatic send_read(logic [31:0] cnt, logic [31:0] ts);
        int gap;
        @(negedge aclk);
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            gap      = $urandom_range(1, 7);
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {ts, cnt};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic release_reads();
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic wait_idle();
        release_reads();
        while (expected_reads.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_all_registers(logic [31:0] vol, logic [31:0] ene, logic [15:0] step,
                                     logic [15:0] lim, logic [31:0] cnt0, logic [31:0] t0);
        set_register(REG_VOLUME_FACTOR, vol);
        set_register(REG_ENERGY_FACTOR, ene);
        set_register(REG_COUNT_DELTA, {16'd0, step});
        set_register(REG_ELASTICITY, {16'd0, lim});
        set_register(REG_INITIAL_COUNT, cnt0);
        set_register(REG_START_TIME, t0);
    endtask

    function automatic logic [31:0] pick_factor();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return WORD_MAX;
            2, 3:    return $urandom;
            default: return $urandom_range(1, 1 << 20);
        endcase
    endfunction

    function automatic logic [31:0] pick_short();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 32'(SHORT_MAX);
            default: return $urandom_range(1, 24);
        endcase
    endfunction

    function automatic logic [31:0] pick_baseline();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return WORD_MAX - $urandom_range(0, 200);
            2, 3:    return $urandom;
            default: return $urandom_range(0, 5000);
        endcase
    endfunction

    // mostly a meter ticking forward, with some noise and reads running backwards
    task automatic run_reads(int n);
        logic [31:0] cnt;
        logic [31:0] ts;
        int          step;
        int          kind;
        cnt  = base_count;
        ts   = base_time;
        step = int'(growth_step);
        for (int i = 0; i < n; i++) begin
            kind = $urandom_range(0, 99);
            if (kind < 82) begin
                cnt = cnt + $urandom_range(0, step + step / 2 + 2);
                ts  = ts + $urandom_range(0, 3);
                send_read(cnt, ts);
            end else if (kind < 90) begin
                send_read($urandom, $urandom);
            end else if (kind < 95) begin
                send_read(cnt - $urandom_range(1, 50), ts);
            end else begin
                send_read(cnt, ts - $urandom_range(1, 50));
            end
        end
    endtask

    task automatic test_reset_defaults();
        send_read(32'd0, 32'd0);    // first read after reset always recalculates
        send_read(32'd1, 32'd1);
        send_read(32'd1, 32'd2);    // no growth, under elasticity
        send_read(32'd3, 32'd5);
        wait_idle();
    endtask

    task automatic test_saturation_and_wrap();
        set_all_registers(WORD_MAX, WORD_MAX, 16'd0, 16'd1, 32'd0, 32'd0);
        send_read(WORD_MAX, 32'd1);     // largest product over one second
        send_read(WORD_MAX, 32'd1);     // no time passed
        send_read(WORD_MAX, 32'd0);     // time went backwards
        wait_idle();
        set_register(REG_ENERGY_FACTOR, 32'd1);
        set_register(REG_INITIAL_COUNT, 32'hFFFF_FFF0);
        set_register(REG_START_TIME, 32'd1000);
        send_read(32'd5, 32'd1010);     // count wrapped past zero
        send_read(32'd3, 32'd1020);     // count went backwards
        wait_idle();
        set_register(REG_VOLUME_FACTOR, '0);
        set_register(REG_ENERGY_FACTOR, '0);
        send_read(32'd123, 32'd1030);
        wait_idle();
    endtask

    task automatic test_growth_limits();
        // baseline at the top: the growth threshold would wrap, so it never fires
        set_all_registers(32'd65536, 32'd65536, SHORT_MAX, SHORT_MAX, WORD_MAX, WORD_MAX);
        send_read(WORD_MAX, 32'd5);
        send_read(WORD_MAX, 32'd6);
        send_read(32'd0, 32'd7);
        wait_idle();
    endtask

    task automatic test_elasticity();
        set_all_registers(32'd3, 32'd70000, SHORT_MAX, 16'd3, 32'd0, 32'd0);
        send_read(32'd100, 32'd1);
        send_read(32'd100, 32'd2);
        send_read(32'd101, 32'd3);
        send_read(32'd102, 32'd4);      // third read since the last one closes the interval
        wait_idle();
        set_register(REG_ELASTICITY, '0);
        send_read(32'd100, 32'd5);
        send_read(32'd100, 32'd5);
        wait_idle();
    endtask

    task automatic test_unused_index();
        set_register(REG_ELASTICITY, 32'(SHORT_MAX));
        send_read(32'd50, 32'd10);
        wait_idle();
        set_register(REG_UNUSED_LO, $urandom);
        set_register(REG_UNUSED_HI, $urandom);
        send_read(32'd50, 32'd11);      // nothing forced: no recalculation
        wait_idle();
    endtask

    task automatic test_random_phases(int phases, int reads_per_phase);
        logic wrote;
        int   pcts[3];
        pcts = '{0, 15, 35};
        for (int p = 0; p < phases; p++) begin
            wait_idle();
            wrote = 1'b0;
            if (p == 0 || $urandom_range(0, 2) == 0) begin
                set_register(REG_VOLUME_FACTOR, pick_factor());
                wrote = 1'b1;
            end
            if (p == 0 || $urandom_range(0, 2) == 0) begin
                set_register(REG_ENERGY_FACTOR, pick_factor());
                wrote = 1'b1;
            end
            if (p == 0 || $urandom_range(0, 2) == 0) begin
                set_register(REG_COUNT_DELTA, pick_short());
                wrote = 1'b1;
            end
            if (p == 0 || $urandom_range(0, 2) == 0) begin
                set_register(REG_ELASTICITY, pick_short());
                wrote = 1'b1;
            end
            if (p == 0 || $urandom_range(0, 2) == 0) begin
                set_register(REG_INITIAL_COUNT, pick_baseline());
                wrote = 1'b1;
            end
            if (!wrote || $urandom_range(0, 2) == 0) begin
                set_register(REG_START_TIME, pick_baseline());
            end
            if ($urandom_range(0, 9) == 0) begin
                set_register($urandom_range(0, 1) ? REG_UNUSED_LO : REG_UNUSED_HI, $urandom);
            end
            gap_pct   = pcts[$urandom_range(0, 2)];
            stall_pct = pcts[$urandom_range(0, 2)];
            run_reads(reads_per_phase);
        end
        wait_idle();
    endtask

    task automatic test_steady_stream(int n);
        gap_pct   = 0;
        stall_pct = 0;
        set_register(REG_COUNT_DELTA, $urandom_range(1, 8));
        set_register(REG_ELASTICITY, $urandom_range(2, 12));
        run_reads(n);
        wait_idle();
    endtask

    initial begin
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b1;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        gap_pct       = 0;
        stall_pct     = 0;
        stall_left    = 0;
        fail_count    = 0;
        reads_sent    = 0;
        reads_checked = 0;
        power_updates = 0;
        cfg_writes    = 0;
        idle_cycles   = 0;
        reset_meter_model();
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        test_reset_defaults();
        test_saturation_and_wrap();
        test_growth_limits();
        test_elasticity();
        test_unused_index();
        test_random_phases(12, 140);
        test_steady_stream(200);

        repeat (END_DRAIN_CYCLES) @(posedge aclk);
        $display("Checked %0d meter reads (%0d power recalculations) over %0d register writes,",
                 reads_checked, power_updates, cfg_writes);
        $display("with saturation, stalled or reversed time, count wrap and bursty handshakes.");
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d failures", fail_count);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
